/* rtl/gcpt_pkg.sv */
// ---------------------------------------------------------------------------
// gcpt_pkg
// shared types and constants for the gait contact phase tracker
// ---------------------------------------------------------------------------
package gcpt_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_OUT
    } state_t;

    localparam logic [2:0] REG_STEP_DURATION   = 3'd0;
    localparam logic [2:0] REG_TRANSITION_TIME = 3'd1;
    localparam logic [2:0] REG_TICK_PERIOD     = 3'd2;
    localparam logic [2:0] REG_FORCE_RISE_MIN  = 3'd3;
    localparam logic [2:0] REG_FORCE_LOAD_MIN  = 3'd4;
    localparam logic [2:0] REG_BODY_WEIGHT     = 3'd5;

    localparam int DIV_STEPS = 16;

    typedef struct packed {
        logic load;
        logic eval;
        logic div_start;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic div_done;
    } sts_t;

endpackage

/* rtl/gait_contact_phase_tracker.sv */
// ---------------------------------------------------------------------------
// gait_contact_phase_tracker
// four-phase gait tracker with odometer, ankle flag and phase fraction
// ---------------------------------------------------------------------------
// channel   dir   bus          content
// s_axis    in    tdata 304b   one control tick
// m_axis    out   tdata 208b   one tracker result
// cfg       in    24b write    six registers, index 0..5
//
// one beat runs through capture, the state update, the bit-serial fraction
// divider (16 quotient steps, then a done check that loads the fraction) and
// the result beat, held for the output handshake; rst_n asynchronously clears
// control, config and gait state to the documented reset values, not the captured
// beat or divider data; the input stays closed until the result beat is taken
module gait_contact_phase_tracker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_idx,
    input  logic [23:0]   cfg_data,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // now_us, left_vert_force, right_vert_force, left_lat_force, right_lat_force,
    // left_fwd_speed, right_fwd_speed, left_pos_x, left_pos_y, left_pos_z,
    // right_pos_x, right_pos_z, right_pos_y
    input  logic [303:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // phase_time, phase_fraction, gait_phase, stance_side, step_count,
    // touchdown_time, ankle_flag, odometer_x, odometer_y, odometer_z,
    // contact_type, estimator_foot
    output logic [207:0]  m_axis_tdata
);
    gcpt_pkg::cmd_t cmd;
    gcpt_pkg::sts_t sts;

    // controller owns the handshake
    gcpt_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_fire(s_axis_tvalid && s_axis_tready),
        .out_fire(m_axis_tvalid && m_axis_tready),
        .sts(sts), .cmd(cmd),
        .in_ready(s_axis_tready), .out_valid(m_axis_tvalid)
    );

    // datapath holds gait state and the divider
    gcpt_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
        .in_data(s_axis_tdata), .out_data(m_axis_tdata)
    );
endmodule

/* rtl/gcpt_ctrl.sv */
// ---------------------------------------------------------------------------
// gcpt_ctrl
// sequencer: capture beat, update state, run divider, present result
// ---------------------------------------------------------------------------
module gcpt_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_fire,
    input  logic             out_fire,
    input  gcpt_pkg::sts_t   sts,
    output gcpt_pkg::cmd_t   cmd,
    output logic             in_ready,
    output logic             out_valid
);
    gcpt_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= gcpt_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gcpt_pkg::ST_IDLE: if (in_fire) state_next = gcpt_pkg::ST_EVAL;
            gcpt_pkg::ST_EVAL: state_next = gcpt_pkg::ST_DIV;
            gcpt_pkg::ST_DIV:  if (sts.div_done) state_next = gcpt_pkg::ST_OUT;
            gcpt_pkg::ST_OUT:  if (out_fire) state_next = gcpt_pkg::ST_IDLE;
            default:           state_next = gcpt_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            gcpt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_fire;
            end
            gcpt_pkg::ST_EVAL:
            begin
                cmd.eval = 1'b1;
                cmd.div_start = 1'b1;
            end
            gcpt_pkg::ST_DIV:
            begin
                cmd.div_step = ~sts.div_done;
                cmd.out_load = sts.div_done;
            end
            gcpt_pkg::ST_OUT: out_valid = 1'b1;
            default: ;
        endcase
    end

    a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("out and in both open");
    a_eval_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.eval) else $error("eval missing after load");
    a_out_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid) else $error("result not presented");
endmodule

/* rtl/gcpt_datapath.sv */
// ---------------------------------------------------------------------------
// gcpt_datapath
// gait state registers, switch rules and restoring fraction divider
// ---------------------------------------------------------------------------
module gcpt_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  gcpt_pkg::cmd_t         cmd,
    output gcpt_pkg::sts_t         sts,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_idx,
    input  logic [23:0]            cfg_data,
    input  logic [303:0]           in_data,
    output logic [207:0]           out_data
);
    // configuration
    logic [23:0] step_dur_reg, trans_reg;
    logic [16:0] tick_reg;
    logic [18:0] rise_reg, loadmin_reg, weight_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_dur_reg <= 24'd400000;
            trans_reg    <= 24'd100000;
            tick_reg     <= 17'd2500;
            rise_reg     <= 19'd800;
            loadmin_reg  <= 19'd3200;
            weight_reg   <= 19'd8624;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                gcpt_pkg::REG_STEP_DURATION:   step_dur_reg <= cfg_data;
                gcpt_pkg::REG_TRANSITION_TIME: trans_reg    <= cfg_data;
                gcpt_pkg::REG_TICK_PERIOD:     tick_reg     <= cfg_data[16:0];
                gcpt_pkg::REG_FORCE_RISE_MIN:  rise_reg     <= cfg_data[18:0];
                gcpt_pkg::REG_FORCE_LOAD_MIN:  loadmin_reg  <= cfg_data[18:0];
                gcpt_pkg::REG_BODY_WEIGHT:     weight_reg   <= cfg_data[18:0];
                default: ;
            endcase
        end
    end

    // captured beat
    logic [303:0] in_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            in_reg <= in_data;
    end

    logic [31:0] now;
    logic signed [19:0] lv, rv, ll, rl;
    logic signed [23:0] ls, rs, lx, ly, lz, rx, ry, rz;
    assign now = in_reg[31:0];
    assign lv  = in_reg[51:32];
    assign rv  = in_reg[71:52];
    assign ll  = in_reg[91:72];
    assign rl  = in_reg[111:92];
    assign ls  = in_reg[135:112];
    assign rs  = in_reg[159:136];
    assign lx  = in_reg[183:160];
    assign ly  = in_reg[207:184];
    assign lz  = in_reg[231:208];
    assign rx  = in_reg[255:232];
    assign rz  = in_reg[279:256];
    assign ry  = in_reg[303:280];

    // state
    logic [31:0] sw_time_reg, td_reg;
    logic [2:0]  phase_reg, contact_reg;
    logic        stance_reg, ankle_reg, efoot_reg;
    logic [15:0] step_reg;
    logic [31:0] odo_x_reg, odo_y_reg, odo_z_reg;
    logic [23:0] period_reg;
    logic signed [19:0] plv_reg, prv_reg, pll_reg, prl_reg;
    logic signed [23:0] pls_reg, prs_reg;

    // rule evaluation, all from the tick-start state
    logic [31:0] t0;
    logic signed [36:0] t10, late_thr, t2, to_thr;
    logic signed [20:0] drv, dlv, dll, drl;
    logic signed [24:0] dls, drs;
    logic signed [24:0] rv10, lv10, mg6;
    logic late, tmo, sw_r, sw_l, ld1, ld3, fl_r, fl_l;
    logic [2:0] ph_n;
    logic [31:0] t_n, td_n;

    always_comb
    begin
        t0 = now - sw_time_reg;
        t10 = 37'(t0) * 37'sd10;
        late_thr = 37'(period_reg) * 37'sd7 + 37'(trans_reg) * 37'sd10;
        t2 = 37'(t0) * 37'sd2;
        to_thr = 37'(period_reg) * 37'sd2 + 37'(trans_reg) * 37'sd2 - 37'(tick_reg);
        late = t10 > late_thr;
        tmo = t2 > to_thr;
        drv = 21'(rv) - 21'(prv_reg);
        dlv = 21'(lv) - 21'(plv_reg);
        dll = 21'(ll) - 21'(pll_reg);
        drl = 21'(rl) - 21'(prl_reg);
        dls = 25'(ls) - 25'(pls_reg);
        drs = 25'(rs) - 25'(prs_reg);
        rv10 = 25'(rv) * 25'sd10;
        lv10 = 25'(lv) * 25'sd10;
        mg6 = 25'(weight_reg) * 25'sd6;
        sw_r = (phase_reg == 3'd4 && (drv >= $signed({2'b00, rise_reg}) || rv10 > mg6) && late)
            || (phase_reg > 3'd2 && tmo);
        sw_l = (phase_reg == 3'd2 && (dlv >= $signed({2'b00, rise_reg}) || lv10 > mg6) && late)
            || (phase_reg < 3'd3 && tmo);
        ld1 = phase_reg == 3'd1 && rv >= $signed({1'b0, loadmin_reg});
        ld3 = phase_reg == 3'd3 && lv >= $signed({1'b0, loadmin_reg});
        // a switch zeroes t, and the ankle flag is only set on a tick without one
        fl_r = (drl >= 21'sd32) || (drl <= -21'sd32);
        fl_l = (dll >= 21'sd32) || (dll <= -21'sd32);
        t_n = (sw_r || sw_l) ? 32'd0 : t0;
        ph_n = phase_reg;
        td_n = td_reg;
        if (sw_r) begin ph_n = 3'd1; td_n = 32'(step_dur_reg); end
        if (ld1) begin ph_n = 3'd2; td_n = t_n; end
        if (sw_l) begin ph_n = 3'd3; td_n = 32'(step_dur_reg); end
        if (ld3) begin ph_n = 3'd4; td_n = t_n; end
    end

    // divider
    logic [31:0] t_reg;
    logic [39:0] rem_reg;
    logic [16:0] q_reg;
    logic [4:0]  cnt_reg;
    logic [16:0] frac_reg;
    logic [39:0] rem_cur;
    logic [39:0] rem_sh;
    logic [32:0] dsub;
    logic [23:0] per_n;

    assign per_n = (sw_r || sw_l) ? step_dur_reg : period_reg;
    // first step starts from d, later steps from the running remainder
    assign rem_cur = (cnt_reg == 5'd0) ? {8'd0, dsub[31:0]} : rem_reg;
    assign rem_sh = {rem_cur[38:0], 1'b0};
    assign dsub = 33'(t_reg) - 33'(trans_reg);
    assign sts.div_done = cnt_reg == 5'(gcpt_pkg::DIV_STEPS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_time_reg <= '0; td_reg <= '0; phase_reg <= 3'd1; stance_reg <= 1'b0;
            step_reg <= '0; odo_x_reg <= '0; odo_y_reg <= '0; odo_z_reg <= '0;
            ankle_reg <= 1'b0; period_reg <= 24'd400000;
            plv_reg <= '0; prv_reg <= '0; pll_reg <= '0; prl_reg <= '0;
            contact_reg <= 3'd4; efoot_reg <= 1'b0; pls_reg <= '0; prs_reg <= '0;
            cnt_reg <= '0; t_reg <= '0;
        end
        else
        begin
            if (cmd.eval)
            begin
                phase_reg <= ph_n;
                td_reg <= td_n;
                period_reg <= per_n;
                t_reg <= t_n;
                if (sw_r || sw_l)
                begin
                    sw_time_reg <= now;
                    step_reg <= step_reg + (sw_r && sw_l ? 16'd2 : 16'd1);
                    stance_reg <= sw_r && !sw_l;
                end
                odo_x_reg <= odo_x_reg + (sw_r ? 32'(rx) : 32'd0) + (sw_l ? 32'(lx) : 32'd0);
                odo_y_reg <= odo_y_reg + (sw_r ? 32'(ry) : 32'd0) + (sw_l ? 32'(ly) : 32'd0);
                odo_z_reg <= odo_z_reg + (sw_r ? 32'(rz) : 32'd0) + (sw_l ? 32'(lz) : 32'd0);
                if (!(sw_r || sw_l) && late &&
                    ((ph_n == 3'd4 && fl_r) || (ph_n == 3'd2 && fl_l)))
                    ankle_reg <= 1'b1;
                else if (sw_r || sw_l)
                    ankle_reg <= 1'b0;
                if (contact_reg == 3'd4 && lv > 20'sd3200)
                    contact_reg <= 3'd1;
                else if (contact_reg == 3'd1 && dls < 25'sd10000 && dls > -25'sd10000)
                begin
                    contact_reg <= 3'd2; efoot_reg <= 1'b0;
                end
                else if (contact_reg == 3'd2 && rv > 20'sd3200)
                    contact_reg <= 3'd3;
                else if (contact_reg == 3'd3 && drs < 25'sd10000 && drs > -25'sd10000)
                begin
                    contact_reg <= 3'd4; efoot_reg <= 1'b1;
                end
                plv_reg <= lv; prv_reg <= rv; pll_reg <= ll; prl_reg <= rl;
                pls_reg <= ls; prs_reg <= rs;
            end
            if (cmd.div_start)
                cnt_reg <= '0;
            else if (cmd.div_step)
                cnt_reg <= cnt_reg + 5'd1;
        end
    end

    // restoring division of d*2^16 by period, one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            q_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_sh >= 40'(period_reg))
            begin
                rem_reg <= rem_sh - 40'(period_reg);
                q_reg <= {q_reg[15:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                q_reg <= {q_reg[15:0], 1'b0};
            end
        end
        if (cmd.out_load)
        begin
            if (dsub[32] || dsub == 33'd0)
                frac_reg <= '0;
            else if (period_reg == 24'd0 || dsub[31:0] >= 32'(period_reg))
                frac_reg <= 17'd65536;
            else
                frac_reg <= q_reg;
        end
    end

    assign out_data = {6'd0, efoot_reg, contact_reg, odo_z_reg, odo_y_reg, odo_x_reg,
                       ankle_reg, td_reg, step_reg, stance_reg, phase_reg, frac_reg, t_reg};

    a_div_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 5'(gcpt_pkg::DIV_STEPS)) else $error("divider overrun");
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 3'd0 && phase_reg < 3'd5) else $error("phase out of range");
    a_contact_range: assert property (@(posedge clk) disable iff (!rst_n)
        contact_reg != 3'd0 && contact_reg < 3'd5) else $error("contact out of range");
endmodule
